// ===== rtl/bmec_pkg.sv =====
// Shared types and constants of the block map extent coalescer.
// Holds the extent record layout, widths, register indexes and reset values.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package bmec_pkg;

   localparam int MAX_EXTENTS = 256;

   localparam int BLK_W  = 32;
   localparam int LEN_W  = 33;
   localparam int CNT_W  = 9;
   localparam int NUM_W  = 8;
   localparam int BYTE_W = 48;
   localparam int BSZ_W  = 17;
   localparam int MAXE_W = 9;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = BSZ_W;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_EXTENTS = CSR_IDX_W'(1);

   localparam logic [BSZ_W-1:0]  BLOCK_SIZE_RST  = BSZ_W'(4096);
   localparam logic [MAXE_W-1:0] MAX_EXTENTS_RST = MAXE_W'(256);

   // Decoupling queue between the classifier and the byte scaler.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One extent, still counted in blocks.
   typedef struct packed {
      logic [BLK_W-1:0] logical;
      logic [BLK_W-1:0] physical;
      logic [LEN_W-1:0] length;
      logic             merged;
      logic             last;
      logic [NUM_W-1:0] number;
      logic             end_map;
   } ext_rec_type;

   // Effective extent limit: zero reads as one, large values are capped.
   function automatic logic [MAXE_W-1:0] limit_of(input logic [MAXE_W-1:0] m);
      logic [MAXE_W-1:0] r;
      r = m;
      if (m == '0) begin
         r = MAXE_W'(1);
      end else if (int'(m) > MAX_EXTENTS) begin
         r = MAXE_W'(MAX_EXTENTS);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/bmec_front.sv =====
// Front end of the coalescer: accepts block mappings and tracks the open extent.
// Emits up to two extent records per transaction (a closed one and a final one).
// Depends on bmec_pkg.
`default_nettype none

module bmec_front
   import bmec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BLK_W-1:0]  req_logical_block,
   input  wire logic [BLK_W-1:0]  req_physical_block,
   input  wire logic              req_first_item,
   input  wire logic              req_final_item,
   input  wire logic [MAXE_W-1:0] max_extents,
   input  wire logic              q_room,
   output logic                   brk_valid,
   output ext_rec_type            brk_rec,
   output logic                   fin_valid,
   output ext_rec_type            fin_rec
);

   logic [BLK_W-1:0] open_logical_ff,  open_logical_in;
   logic [BLK_W-1:0] open_physical_ff, open_physical_in;
   logic [LEN_W-1:0] open_length_ff,   open_length_in;
   logic             open_merged_ff,   open_merged_in;
   logic [CNT_W-1:0] counter_ff,       counter_in;
   logic             active_ff,        active_in;
   logic             stopped_ff,       stopped_in;

   logic              accept;
   logic              contig;
   logic              stop_hit;
   logic [CNT_W:0]    cnt_inc;
   logic [MAXE_W-1:0] lim;

   assign req_ready = q_room;
   assign accept    = req_valid && req_ready;
   assign lim       = limit_of(max_extents);
   assign cnt_inc   = {1'b0, counter_ff} + (CNT_W+1)'(1);
   assign contig    = ({2'b00, open_physical_ff} + {1'b0, open_length_ff})
                      == {2'b00, req_physical_block};

   always_comb begin
      open_logical_in  = open_logical_ff;
      open_physical_in = open_physical_ff;
      open_length_in   = open_length_ff;
      open_merged_in   = open_merged_ff;
      counter_in       = counter_ff;
      active_in        = active_ff;
      stopped_in       = stopped_ff;
      stop_hit         = 1'b0;
      brk_valid        = 1'b0;
      fin_valid        = 1'b0;

      brk_rec.logical  = open_logical_ff;
      brk_rec.physical = open_physical_ff;
      brk_rec.length   = open_length_ff;
      brk_rec.merged   = open_merged_ff;
      brk_rec.last     = 1'b0;
      brk_rec.number   = counter_ff[NUM_W-1:0];
      brk_rec.end_map  = 1'b0;

      if (accept) begin
         if (req_first_item) begin
            open_logical_in  = req_logical_block;
            open_physical_in = req_physical_block;
            open_length_in   = LEN_W'(1);
            open_merged_in   = 1'b0;
            counter_in       = '0;
            active_in        = 1'b1;
            stopped_in       = 1'b0;
            if (req_final_item) begin
               fin_valid = 1'b1;
               active_in = 1'b0;
            end
         end else if (active_ff && !stopped_ff) begin
            if (req_physical_block != '0) begin
               priority if (contig) begin
                  open_length_in = open_length_ff + LEN_W'(1);
                  open_merged_in = 1'b1;
               end else if (cnt_inc >= {1'b0, lim}) begin
                  // Extent limit: close the map here and drop the item.
                  brk_valid       = 1'b1;
                  brk_rec.end_map = 1'b1;
                  active_in       = 1'b0;
                  stopped_in      = 1'b1;
                  stop_hit        = 1'b1;
               end else begin
                  brk_valid        = 1'b1;
                  counter_in       = cnt_inc[CNT_W-1:0];
                  open_logical_in  = req_logical_block;
                  open_physical_in = req_physical_block;
                  open_length_in   = LEN_W'(1);
                  open_merged_in   = 1'b0;
               end
            end
            if (req_final_item && !stop_hit) begin
               fin_valid = 1'b1;
               active_in = 1'b0;
            end
         end
      end

      // The final record describes the extent as it stands after this item.
      fin_rec.logical  = open_logical_in;
      fin_rec.physical = open_physical_in;
      fin_rec.length   = open_length_in;
      fin_rec.merged   = open_merged_in;
      fin_rec.last     = 1'b1;
      fin_rec.number   = counter_in[NUM_W-1:0];
      fin_rec.end_map  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         active_ff  <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         counter_ff <= counter_in;
         active_ff  <= active_in;
         stopped_ff <= stopped_in;
      end
      open_logical_ff  <= open_logical_in;
      open_physical_ff <= open_physical_in;
      open_length_ff   <= open_length_in;
      open_merged_ff   <= open_merged_in;
   end

endmodule

`default_nettype wire

// ===== rtl/bmec_queue.sv =====
// Short extent record queue between the front end and the byte scaler.
// Takes up to two records per cycle and releases one; depends on bmec_pkg.
`default_nettype none

module bmec_queue
   import bmec_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_a_valid,
   input  wire ext_rec_type push_a,
   input  wire logic        push_b_valid,
   input  wire ext_rec_type push_b,
   input  wire logic        pop,
   output logic             head_valid,
   output ext_rec_type      head,
   output logic             room,
   output logic [QCNT_W-1:0] fill
);

   ext_rec_type       entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff,  count_in;
   logic [QPTR_W-1:0] b_ptr;

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign room       = (count_ff <= QCNT_W'(QDEPTH - 2));
   assign fill       = count_ff;
   assign b_ptr      = push_a_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_a_valid) + QPTR_W'(push_b_valid);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_a_valid) + QCNT_W'(push_b_valid)
                  - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push_a_valid) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_b_valid) begin
         entry_ff[b_ptr] <= push_b;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/bmec_back.sv =====
// Back end of the coalescer: scales extent records from blocks to bytes.
// A multiply stage and an output register, stalled together; uses bmec_pkg.
`default_nettype none

module bmec_back
   import bmec_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire ext_rec_type       head,
   output logic                   pop,
   input  wire logic [BSZ_W-1:0]  block_size,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [BYTE_W-1:0]      rsp_extent_logical,
   output logic [BYTE_W-1:0]      rsp_extent_physical,
   output logic [BYTE_W-1:0]      rsp_extent_length,
   output logic                   rsp_merged_flag,
   output logic                   rsp_last_extent_flag,
   output logic [NUM_W-1:0]       rsp_extent_number,
   output logic                   rsp_end_of_map
);

   logic advance;

   logic [BLK_W+BSZ_W-1:0] prod_logical;
   logic [BLK_W+BSZ_W-1:0] prod_physical;
   logic [LEN_W+BSZ_W-1:0] prod_length;

   logic              s1_valid_ff;
   logic [BYTE_W-1:0] s1_logical_ff, s1_physical_ff, s1_length_ff;
   logic              s1_merged_ff, s1_last_ff, s1_end_ff;
   logic [NUM_W-1:0]  s1_number_ff;

   logic              out_valid_ff;
   logic [BYTE_W-1:0] out_logical_ff, out_physical_ff, out_length_ff;
   logic              out_merged_ff, out_last_ff, out_end_ff;
   logic [NUM_W-1:0]  out_number_ff;

   assign advance = !out_valid_ff || rsp_ready;
   assign pop     = advance && head_valid;

   assign prod_logical  = head.logical  * block_size;
   assign prod_physical = head.physical * block_size;
   assign prod_length   = head.length   * block_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= head_valid;
         out_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s1_logical_ff   <= prod_logical[BYTE_W-1:0];
         s1_physical_ff  <= prod_physical[BYTE_W-1:0];
         s1_length_ff    <= prod_length[BYTE_W-1:0];
         s1_merged_ff    <= head.merged;
         s1_last_ff      <= head.last;
         s1_number_ff    <= head.number;
         s1_end_ff       <= head.end_map;
         out_logical_ff  <= s1_logical_ff;
         out_physical_ff <= s1_physical_ff;
         out_length_ff   <= s1_length_ff;
         out_merged_ff   <= s1_merged_ff;
         out_last_ff     <= s1_last_ff;
         out_number_ff   <= s1_number_ff;
         out_end_ff      <= s1_end_ff;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_extent_logical   = out_logical_ff;
   assign rsp_extent_physical  = out_physical_ff;
   assign rsp_extent_length    = out_length_ff;
   assign rsp_merged_flag      = out_merged_ff;
   assign rsp_last_extent_flag = out_last_ff;
   assign rsp_extent_number    = out_number_ff;
   assign rsp_end_of_map       = out_end_ff;

endmodule

`default_nettype wire

// ===== rtl/block_map_extent_coalescer_unit.sv =====
// Top level of the block map extent coalescer: configuration registers,
// front end, record queue and byte scaler. Depends on bmec_pkg, bmec_front,
// bmec_queue and bmec_back.
//
//   channel | direction | handshake            | carries
//   --------+-----------+----------------------+------------------------------
//   req_    | in        | req_valid/req_ready  | one block mapping per transaction
//   rsp_    | out       | rsp_valid/rsp_ready  | one extent per transaction
//   csr_    | in        | csr_write_enable     | block_size, max_extents writes
//
// The front end takes one mapping per cycle whenever the queue has room for
// two records; the result side delivers one extent per cycle while rsp_ready
// is high, set by the single output register. After a mapping is accepted,
// its extents are written into the queue, then pass the multiply stage and
// the output register before they appear on rsp_.
// Reset is synchronous and active high; it clears the map state and the queue.
// A stalled rsp_ready halts the scaler, and the four-entry queue keeps taking
// mappings until fewer than two slots are free.
`default_nettype none

module block_map_extent_coalescer_unit
   import bmec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [BLK_W-1:0]      req_logical_block,
   input  wire logic [BLK_W-1:0]      req_physical_block,
   input  wire logic                  req_first_item,
   input  wire logic                  req_final_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [BYTE_W-1:0]          rsp_extent_logical,
   output logic [BYTE_W-1:0]          rsp_extent_physical,
   output logic [BYTE_W-1:0]          rsp_extent_length,
   output logic                       rsp_merged_flag,
   output logic                       rsp_last_extent_flag,
   output logic [NUM_W-1:0]           rsp_extent_number,
   output logic                       rsp_end_of_map,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   // Configuration registers. Writes to unknown indexes are ignored.
   logic [BSZ_W-1:0]  block_size_ff;
   logic [MAXE_W-1:0] max_extents_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= BLOCK_SIZE_RST;
         max_extents_ff <= MAX_EXTENTS_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_write_data[BSZ_W-1:0];
            CSR_MAX_EXTENTS: max_extents_ff <= csr_write_data[MAXE_W-1:0];
            default: ;
         endcase
      end
   end

   // The front end classifies each mapping as extend, break, stop or final
   // and hands closed extents, still in block units, to the queue.
   logic        q_room;
   logic        brk_valid;
   logic        fin_valid;
   ext_rec_type brk_rec;
   ext_rec_type fin_rec;

   bmec_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_logical_block  (req_logical_block),
      .req_physical_block (req_physical_block),
      .req_first_item     (req_first_item),
      .req_final_item     (req_final_item),
      .max_extents        (max_extents_ff),
      .q_room             (q_room),
      .brk_valid          (brk_valid),
      .brk_rec            (brk_rec),
      .fin_valid          (fin_valid),
      .fin_rec            (fin_rec)
   );

   // A break record always precedes the final record of the same mapping,
   // so the queue writes them in that order.
   logic              head_valid;
   ext_rec_type       head;
   logic              pop;
   logic [QCNT_W-1:0] q_fill;

   bmec_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push_a_valid (brk_valid),
      .push_a       (brk_rec),
      .push_b_valid (fin_valid),
      .push_b       (fin_rec),
      .pop          (pop),
      .head_valid   (head_valid),
      .head         (head),
      .room         (q_room),
      .fill         (q_fill)
   );

   // The back end multiplies block counts by block_size and presents
   // the extent on the result channel.
   bmec_back u_back (
      .clock                (clock),
      .reset                (reset),
      .head_valid           (head_valid),
      .head                 (head),
      .pop                  (pop),
      .block_size           (block_size_ff),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_extent_logical   (rsp_extent_logical),
      .rsp_extent_physical  (rsp_extent_physical),
      .rsp_extent_length    (rsp_extent_length),
      .rsp_merged_flag      (rsp_merged_flag),
      .rsp_last_extent_flag (rsp_last_extent_flag),
      .rsp_extent_number    (rsp_extent_number),
      .rsp_end_of_map       (rsp_end_of_map)
   );

   // The queue never holds more records than it has entries.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_fill <= QCNT_W'(QDEPTH))
      else $error("extent queue overfilled");

   // A mapping is only taken when both of its possible records fit.
   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (q_fill <= QCNT_W'(QDEPTH - 2)))
      else $error("mapping accepted without room for two records");

   // An extent that ends the file always ends the map as well.
   a_last_ends_map: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_extent_flag) |-> rsp_end_of_map)
      else $error("last extent without end of map");

   // Nothing is presented in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== tb/block_map_extent_coalescer_unit_tb.sv =====
// Self-checking testbench for block_map_extent_coalescer_unit.
// Tracks the extent state of every map and checks each extent transaction.
// Depends on bmec_pkg and the block's top level; reads no files.

module block_map_extent_coalescer_unit_tb
   import bmec_pkg::*;
();

   // Generous cycle budget for roughly 1050 mappings, at most two extents each,
   // with 27% idle and stall rates.
   localparam int CYCLE_LIMIT   = 400000;
   // The block answers through its queue and back end registers; this leaves margin.
   localparam int SETTLE_CYCLES = 12;

   // Register indexes that decode to nothing; writes there must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_IDX_W'(3);

   // One extent as it leaves the block, already scaled to bytes.
   typedef struct packed {
      logic [BYTE_W-1:0] logical;
      logic [BYTE_W-1:0] physical;
      logic [BYTE_W-1:0] length;
      logic              merged;
      logic              last;
      logic [NUM_W-1:0]  number;
      logic              end_map;
   } extent_type;

   // Follows the map state of the block transaction by transaction and keeps
   // the extents that are owed, oldest first.
   class extent_tracker_type;
      logic [BSZ_W-1:0]  block_size    = BLOCK_SIZE_RST;
      logic [MAXE_W-1:0] max_extents   = MAX_EXTENTS_RST;
      logic [BLK_W-1:0]  open_logical  = '0;
      logic [BLK_W-1:0]  open_physical = '0;
      logic [LEN_W-1:0]  open_blocks   = '0;
      logic              open_merged   = 1'b0;
      logic [CNT_W-1:0]  extent_count  = '0;
      bit                map_active    = 1'b0;
      bit                map_stopped   = 1'b0;
      extent_type        extents_due[$];
      int                errors        = 0;

      function void write_reg(input logic [CSR_IDX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BLOCK_SIZE:  block_size = data[BSZ_W-1:0];
            CSR_MAX_EXTENTS: max_extents = data[MAXE_W-1:0];
            default: ;
         endcase
      endfunction

      function void open_at(input logic [BLK_W-1:0] lb, input logic [BLK_W-1:0] pb);
         open_logical  = lb;
         open_physical = pb;
         open_blocks   = LEN_W'(1);
         open_merged   = 1'b0;
      endfunction

      function void emit_extent(input bit last, input bit end_map);
         extent_type  e;
         logic [63:0] scale;
         scale     = 64'(block_size);
         e.logical  = BYTE_W'(64'(open_logical) * scale);
         e.physical = BYTE_W'(64'(open_physical) * scale);
         e.length   = BYTE_W'(64'(open_blocks) * scale);
         e.merged   = open_merged;
         e.last     = last;
         e.number   = extent_count[NUM_W-1:0];
         e.end_map  = end_map;
         extents_due = {extents_due, e};
      endfunction

      function void note_mapping(input logic [BLK_W-1:0] lb, input logic [BLK_W-1:0] pb,
                                 input bit is_first, input bit is_last);
         logic [MAXE_W-1:0] cap;
         cap = max_extents;
         if (cap == '0) begin
            cap = MAXE_W'(1);
         end else if (int'(cap) > MAX_EXTENTS) begin
            cap = MAXE_W'(MAX_EXTENTS);
         end
         if (is_first) begin
            open_at(lb, pb);
            extent_count = '0;
            map_active   = 1'b1;
            map_stopped  = 1'b0;
            if (is_last) begin
               emit_extent(1'b1, 1'b1);
               map_active = 1'b0;
            end
            return;
         end
         if (!map_active || map_stopped) begin
            return;
         end
         if (pb != '0) begin
            if (64'(open_physical) + 64'(open_blocks) == 64'(pb)) begin
               open_blocks = open_blocks + LEN_W'(1);
               open_merged = 1'b1;
            end else if ({1'b0, extent_count} + 10'd1 >= {1'b0, cap}) begin
               emit_extent(1'b0, 1'b1);
               map_active  = 1'b0;
               map_stopped = 1'b1;
               return;
            end else begin
               emit_extent(1'b0, 1'b0);
               extent_count = extent_count + CNT_W'(1);
               open_at(lb, pb);
            end
         end
         if (is_last) begin
            emit_extent(1'b1, 1'b1);
            map_active = 1'b0;
         end
      endfunction

      function int field_differs(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            return 1;
         end
         return 0;
      endfunction

      function void check_extent(input extent_type got);
         extent_type want;
         if (extents_due.size() == 0) begin
            $display("%0t: extent arrived, expected none, actual logical 0x%0h number %0d",
                     $time, got.logical, got.number);
            errors++;
            return;
         end
         want = extents_due.pop_front();
         errors += field_differs("extent_logical", 64'(want.logical), 64'(got.logical));
         errors += field_differs("extent_physical", 64'(want.physical), 64'(got.physical));
         errors += field_differs("extent_length", 64'(want.length), 64'(got.length));
         errors += field_differs("merged_flag", 64'(want.merged), 64'(got.merged));
         errors += field_differs("last_extent_flag", 64'(want.last), 64'(got.last));
         errors += field_differs("extent_number", 64'(want.number), 64'(got.number));
         errors += field_differs("end_of_map", 64'(want.end_map), 64'(got.end_map));
      endfunction
   endclass

   // Every input of the block starts at a known value; reset is held high
   // from time zero until the main sequence releases it.
   logic                  clock                = 1'b0;
   logic                  reset                = 1'b1;
   logic                  req_valid            = 1'b0;
   logic                  req_ready;
   logic [BLK_W-1:0]      req_logical_block    = '0;
   logic [BLK_W-1:0]      req_physical_block   = '0;
   logic                  req_first_item       = 1'b0;
   logic                  req_final_item       = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready            = 1'b0;
   logic [BYTE_W-1:0]     rsp_extent_logical;
   logic [BYTE_W-1:0]     rsp_extent_physical;
   logic [BYTE_W-1:0]     rsp_extent_length;
   logic                  rsp_merged_flag;
   logic                  rsp_last_extent_flag;
   logic [NUM_W-1:0]      rsp_extent_number;
   logic                  rsp_end_of_map;
   logic                  csr_write_enable     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index            = '0;
   logic [CSR_DATA_W-1:0] csr_write_data       = '0;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   // Both drop to zero for one whole phase to run the block at full rate.
   int idle_pct    = 27;
   int stall_pct   = 27;
   int cycle_count = 0;

   extent_tracker_type tracker;

   block_map_extent_coalescer_unit i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_logical_block    (req_logical_block),
      .req_physical_block   (req_physical_block),
      .req_first_item       (req_first_item),
      .req_final_item       (req_final_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_extent_logical   (rsp_extent_logical),
      .rsp_extent_physical  (rsp_extent_physical),
      .rsp_extent_length    (rsp_extent_length),
      .rsp_merged_flag      (rsp_merged_flag),
      .rsp_last_extent_flag (rsp_last_extent_flag),
      .rsp_extent_number    (rsp_extent_number),
      .rsp_end_of_map       (rsp_end_of_map),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // The receiver stalls at random. A fresh decision is made every cycle, so
   // stalls land on every phase of the block's output pipeline.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Both monitors sample at the rising edge, before any of this edge's
   // nonblocking updates, so they see exactly what the block saw. A result
   // can never come from a transaction accepted at the same edge, so the
   // order of the two calls does not matter.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            tracker.check_extent({rsp_extent_logical, rsp_extent_physical,
                                  rsp_extent_length, rsp_merged_flag,
                                  rsp_last_extent_flag, rsp_extent_number,
                                  rsp_end_of_map});
         end
         if (req_valid && req_ready) begin
            tracker.note_mapping(req_logical_block, req_physical_block,
                                 req_first_item, req_final_item);
         end
      end
   end

   // A stuck handshake or a lost extent ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one mapping and returns at the edge that accepts it. Valid is
   // left high so that a back-to-back transaction needs no second update
   // in the same time step; the idle loop lowers it when the sender pauses.
   task automatic send_mapping(input logic [BLK_W-1:0] lb, input logic [BLK_W-1:0] pb,
                               input bit is_first, input bit is_last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_logical_block  <= lb;
      req_physical_block <= pb;
      req_first_item     <= is_first;
      req_final_item     <= is_last;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Sends one map: a first mapping, then mappings mostly in logical
   // order that mostly continue the physical run, with holes and jumps mixed
   // in. A map sent without its final mapping is left open for noise or the
   // next first mapping to hit.
   task automatic send_map(input int n_items, input int jump_pct, input bit closed);
      logic [BLK_W-1:0] lb;
      logic [BLK_W-1:0] pb;
      logic [BLK_W-1:0] prev;
      int               r;
      lb = $urandom;
      pb = ($urandom_range(7) == 0) ? '0 : BLK_W'($urandom);
      send_mapping(lb, pb, 1'b1, closed && n_items == 1);
      prev = pb;
      for (int i = 1; i < n_items; i++) begin
         r = $urandom_range(99);
         if (r < jump_pct) begin
            // A few jumps land at the top of the block space.
            if ($urandom_range(9) == 0) begin
               pb = 32'hFFFF_FFFF - BLK_W'($urandom_range(3));
            end else begin
               pb = $urandom;
            end
         end else if (r < jump_pct + 12) begin
            pb = '0;
         end else begin
            pb = prev + BLK_W'(1);
         end
         if (pb != '0) begin
            prev = pb;
         end
         // Logical order is not enforced by the block, so it is broken now and then.
         lb = ($urandom_range(99) < 3) ? BLK_W'($urandom) : lb + BLK_W'(1);
         send_mapping(lb, pb, 1'b0, closed && i == n_items - 1);
      end
   endtask

   // Maps of mostly short length, a few longer ones, and stray non-first
   // mappings in between. Stray mappings do not count toward the target.
   task automatic run_random_phase(input int target);
      int sent;
      int n;
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(99) < 8) begin
            send_mapping($urandom, $urandom, 1'b0, 1'($urandom_range(1)));
         end
         n = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         send_map(n, $urandom_range(5, 60), $urandom_range(99) < 85);
         sent += n;
      end
   endtask

   // Writes both registers and one index that decodes to nothing, one per
   // cycle, with the write enable held high across the burst.
   task automatic set_registers(input logic [BSZ_W-1:0] bs, input logic [MAXE_W-1:0] me,
                                input logic [CSR_IDX_W-1:0] spare);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_BLOCK_SIZE;
      csr_write_data   <= CSR_DATA_W'(bs);
      tracker.write_reg(CSR_BLOCK_SIZE, CSR_DATA_W'(bs));
      @(posedge clock);
      csr_index      <= CSR_MAX_EXTENTS;
      csr_write_data <= CSR_DATA_W'(me);
      tracker.write_reg(CSR_MAX_EXTENTS, CSR_DATA_W'(me));
      @(posedge clock);
      csr_index      <= spare;
      csr_write_data <= junk;
      tracker.write_reg(spare, junk);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Stops offering mappings and waits until every owed extent has been
   // delivered. Mappings that produce no extent may still be in flight, so
   // a few more cycles pass before the block is treated as idle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.extents_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      tracker = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the reset register values.
      // Nothing is open yet, so neither of these produces an extent.
      send_mapping(32'd5, 32'd9, 1'b0, 1'b0);
      send_mapping(32'd6, 32'd0, 1'b0, 1'b1);
      // A first and final mapping together gives one finished extent at once.
      send_mapping(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      // A first mapping on a hole still opens an extent at physical block 0;
      // the run then grows across a later hole and breaks at the top block.
      send_mapping(32'd0, 32'd0, 1'b1, 1'b0);
      send_mapping(32'd1, 32'd1, 1'b0, 1'b0);
      send_mapping(32'd2, 32'd0, 1'b0, 1'b0);
      send_mapping(32'd3, 32'd2, 1'b0, 1'b0);
      send_mapping(32'd4, 32'hFFFF_FFFF, 1'b0, 1'b0);
      // A final mapping on a hole closes the open extent with the last flag.
      send_mapping(32'd5, 32'd0, 1'b0, 1'b1);
      // The map has ended, so this one is dropped.
      send_mapping(32'd9, 32'd7, 1'b0, 1'b0);
      // A break on the final mapping gives two extents, here with the
      // logical block running backward.
      send_mapping(32'd10, 32'd100, 1'b1, 1'b0);
      send_mapping(32'd3, 32'd200, 1'b0, 1'b1);
      // A first mapping while a map is open throws the open extent away.
      send_mapping(32'd1, 32'd50, 1'b1, 1'b0);
      send_mapping(32'd2, 32'd51, 1'b0, 1'b0);
      send_mapping(32'd7, 32'd70, 1'b1, 1'b0);
      send_mapping(32'd8, 32'd71, 1'b0, 1'b0);
      send_mapping(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0);
      send_mapping(32'h8000_0001, 32'h8000_0000, 1'b0, 1'b1);
      // A run that reaches the last block cannot continue into block 0.
      send_mapping(32'd0, 32'hFFFF_FFFE, 1'b1, 1'b0);
      send_mapping(32'd1, 32'hFFFF_FFFF, 1'b0, 1'b0);
      send_mapping(32'd2, 32'd0, 1'b0, 1'b0);
      send_mapping(32'd3, 32'd1, 1'b0, 1'b1);
      wait_idle();

      // Random maps under a range of settings. One extent per map stops the
      // map on every break; a zero limit behaves like one.
      set_registers(BSZ_W'(1), MAXE_W'(1), CSR_SPARE_LO);
      run_random_phase(105);
      wait_idle();
      set_registers(BSZ_W'(65536), MAXE_W'(2), CSR_SPARE_HI);
      run_random_phase(105);
      wait_idle();
      set_registers(BSZ_W'(0), MAXE_W'(0), CSR_SPARE_LO);
      run_random_phase(105);
      wait_idle();
      set_registers(BSZ_W'($urandom_range(1, 65536)), MAXE_W'($urandom_range(3, 6)),
                    CSR_SPARE_HI);
      run_random_phase(105);
      wait_idle();

      // An oversized limit is capped; a long map of nothing but breaks runs
      // the extent number through its full range and into the cap.
      set_registers(BSZ_W'(4096), MAXE_W'(511), CSR_SPARE_LO);
      send_map(270, 100, 1'b1);
      wait_idle();

      // Full rate on both sides for one phase.
      idle_pct  = 0;
      stall_pct = 0;
      set_registers(BSZ_W'(65535), MAXE_W'(256), CSR_SPARE_HI);
      run_random_phase(105);
      wait_idle();
      idle_pct  = 27;
      stall_pct = 27;

      for (int p = 0; p < 2; p++) begin
         set_registers(BSZ_W'($urandom_range(1, 65536)), MAXE_W'($urandom_range(0, 511)),
                       (p == 0) ? CSR_SPARE_LO : CSR_SPARE_HI);
         run_random_phase(105);
         wait_idle();
      end

      if (tracker.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
